[rtl/lphs_pkg.sv]
`default_nettype none

package lphs_pkg;

   localparam int SLOTS      = 1024;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int HALF_SLOTS = SLOTS / 2;
   localparam int CNT_W      = SLOT_BITS;
   localparam int KEY_W      = 64;
   localparam int ENTRIES_W  = 11;

   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOTS - 1);
   localparam logic [CNT_W-1:0]     CNT_FULL  = CNT_W'(HALF_SLOTS - 1);

   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [SLOT_BITS-1:0] slot_addr_type;
   typedef logic [CNT_W-1:0]     count_type;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type  operation;
      key_type key;
   } req_payload_type;

   typedef struct packed {
      logic                 found;
      status_type           status;
      logic [ENTRIES_W-1:0] entries;
   } rsp_payload_type;

   typedef struct packed {
      logic          we;
      slot_addr_type waddr;
      key_type       wdata;
      slot_addr_type raddr;
   } mem_req_type;

endpackage

`default_nettype wire

[rtl/lphs_stream_if.sv]
`default_nettype none

interface lphs_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/lphs_slot_mem.sv]
`default_nettype none

module lphs_slot_mem (
   input  wire                    clock,
   input  lphs_pkg::mem_req_type  mem_req,
   output lphs_pkg::key_type      rd_data
);
   import lphs_pkg::*;

   key_type slot_mem [SLOTS];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         slot_mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= slot_mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/lphs_ctrl.sv]
`default_nettype none

module lphs_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   lphs_stream_if.sink            req_chan,
   lphs_stream_if.source          rsp_chan,
   output lphs_pkg::mem_req_type  mem_req,
   input  lphs_pkg::key_type      rd_data
);
   import lphs_pkg::*;

   state_type       state_ff, state_in;
   slot_addr_type   clr_ff, clr_in;
   slot_addr_type   addr_ff, addr_in;
   op_type          op_ff, op_in;
   key_type         key_ff, key_in;
   count_type       count_ff, count_in;
   rsp_payload_type res_ff, res_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_ready;
   slot_addr_type   home;
   slot_addr_type   next_addr;

   assign home      = req_chan.payload.key[SLOT_BITS-1:0];
   assign next_addr = SLOT_BITS'(addr_ff + 1'b1);

   // The slot write of an insert lands before the next item can issue its
   // first read, so reads and writes of one entry never overlap.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      req_ready    = 1'b0;
      mem_req      = '{we: 1'b0, waddr: addr_ff, wdata: key_ff, raddr: addr_ff};

      case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            mem_req.wdata = '0;
            clr_in        = SLOT_BITS'(clr_ff + 1'b1);
            if (clr_ff == SLOT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               op_in          = req_chan.payload.operation;
               key_in         = req_chan.payload.key;
               addr_in        = home;
               mem_req.raddr  = home;
               res_in.found   = 1'b0;
               res_in.status  = ST_OK;
               res_in.entries = ENTRIES_W'(count_ff);
               if (req_chan.payload.key == '0) begin
                  res_in.status = ST_ZERO;
                  state_in      = S_DONE;
               end else if (req_chan.payload.operation == OP_INSERT &&
                            count_ff >= CNT_FULL) begin
                  res_in.status = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (rd_data == '0) begin
               if (op_ff == OP_INSERT) begin
                  mem_req.we     = 1'b1;
                  count_in       = CNT_W'(count_ff + 1'b1);
                  res_in.entries = ENTRIES_W'(CNT_W'(count_ff + 1'b1));
               end
               state_in = S_DONE;
            end else if (op_ff == OP_LOOKUP && rd_data == key_ff) begin
               res_in.found = 1'b1;
               state_in     = S_DONE;
            end else begin
               addr_in       = next_addr;
               mem_req.raddr = next_addr;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff <= addr_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/linear_probe_hash_set.sv]
// channel   dir  beat payload                          handshake
// req_chan  in   operation, key                       valid/ready
// rsp_chan  out  found, status, entries               valid/ready
//
// One item at a time: S_IDLE takes it, S_PROBE walks P slots (P = 1 on a direct hit),
// then S_DONE hands the result on. Zero keys and refused inserts skip S_PROBE; the
// single read port of the slot memory paces the probe walk, one slot per cycle.
// After reset a clearing pass writes all SLOTS slots, req_ready low.
// The result sits in an output register; the next beat is taken while it
// waits, and a finished item holds until that register frees.
`default_nettype none

module linear_probe_hash_set (
   input  wire            clock,
   input  wire            reset,
   lphs_stream_if.sink    req_chan,
   lphs_stream_if.source  rsp_chan
);
   import lphs_pkg::*;

   mem_req_type mem_req;
   key_type     rd_data;

   lphs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   lphs_slot_mem u_slot_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

[rtl/lphs_checker.sv]
`default_nettype none

module lphs_protocol_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input lphs_pkg::rsp_payload_type     rsp_payload
);
   import lphs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found |-> rsp_payload.status == ST_OK)
      else $error("found with error status");

   a_below_half: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_payload.entries) < HALF_SLOTS)
      else $error("entry count reached half capacity");

endmodule

bind linear_probe_hash_set lphs_protocol_checker u_lphs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire
